// ----- hdl/msh_pkg.sv -----
// shared constants, codes, types and the size bin function for the message size histogram
package msh_pkg;

    localparam int PEERS       = 1024;
    localparam int NUM_BINS    = 12;
    localparam int PEER_W      = $clog2(PEERS);
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int EXT_W       = 11;
    localparam int BYTES_W     = 48;
    localparam int CNT_W       = 64;
    localparam int FIRST_LIMIT = 64;

    // command codes
    localparam logic [1:0] CMD_RECORD    = 2'd0;
    localparam logic [1:0] CMD_READ_BIN  = 2'd1;
    localparam logic [1:0] CMD_READ_PEER = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_SEND = 2'd1;
    localparam logic [1:0] DIR_RECV = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_PEER_RANGE = 2'd1;
    localparam logic [1:0] ST_IDX_RANGE  = 2'd2;
    localparam logic [1:0] ST_UNUSED     = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

    // number of power-of-four limits the size exceeds, which is the bin index
    function automatic logic [BIN_W-1:0] bin_of(input logic [BYTES_W-1:0] b);
        int cnt;
        cnt = 0;
        for (int i = 0; i < NUM_BINS - 1; i++) begin
            if (64'(b) > (64'(FIRST_LIMIT) << (2 * i))) begin
                cnt = cnt + 1;
            end
        end
        return BIN_W'(cnt);
    endfunction

endpackage

// ----- hdl/msh_if.sv -----
// valid/ready channel interfaces for message events and read results

interface msh_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [47:0]        bytes;
    logic [1:0]         direction;
    logic signed [10:0] peer;
    logic [9:0]         read_index;

    modport source (output valid, cmd, bytes, direction, peer, read_index, input ready);
    modport sink   (input valid, cmd, bytes, direction, peer, read_index, output ready);
endinterface

interface msh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] bin_count;
    logic [63:0] sent_bytes;
    logic [63:0] recv_bytes;
    logic [10:0] peer_extent;

    modport source (output valid, status, bin_count, sent_bytes, recv_bytes, peer_extent,
                    input ready);
    modport sink   (input valid, status, bin_count, sent_bytes, recv_bytes, peer_extent,
                    output ready);
endinterface

// ----- hdl/msh_ctrl.sv -----
// controller state machine: memory clear sweep, beat intake, commit and result valid
module msh_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  msh_pkg::t_dp_stat  i_stat,
    output msh_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_commit    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.clear_step = (r_state == S_CLEAR);
    assign o_cmd.capture    = w_accept;
    assign o_cmd.commit     = w_commit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hdl/msh_dp.sv -----
// datapath: bin counters, per-peer total memories, extent and result register
module msh_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msh_pkg::t_dp_cmd   i_cmd,
    output msh_pkg::t_dp_stat  o_stat,
    input  logic [1:0]         i_in_cmd,
    input  logic [47:0]        i_bytes,
    input  logic [1:0]         i_direction,
    input  logic signed [10:0] i_peer,
    input  logic [9:0]         i_read_index,
    output logic [1:0]         o_status,
    output logic [63:0]        o_bin_count,
    output logic [63:0]        o_sent_bytes,
    output logic [63:0]        o_recv_bytes,
    output logic [10:0]        o_peer_extent
);

    // captured beat
    logic [1:0]                   r_cmd;
    logic [47:0]                  r_bytes;
    logic [1:0]                   r_dir;
    logic signed [10:0]           r_peer;
    logic [9:0]                   r_idx;
    logic [msh_pkg::BIN_W-1:0]    r_bin;

    // counters and memories
    logic [63:0]                  r_bins [msh_pkg::NUM_BINS];
    logic [63:0]                  sent_mem [msh_pkg::PEERS];
    logic [63:0]                  recv_mem [msh_pkg::PEERS];
    logic [63:0]                  r_sent_rd;
    logic [63:0]                  r_recv_rd;
    logic [msh_pkg::PEER_W-1:0]   r_clr_addr;
    logic [msh_pkg::EXT_W-1:0]    r_ext, n_ext;

    // result register
    logic [1:0]                   r_status, n_status;
    logic [63:0]                  r_bc, n_bc;
    logic [63:0]                  r_sb, n_sb;
    logic [63:0]                  r_rb, n_rb;

    logic [msh_pkg::PEER_W-1:0]   w_rd_addr;
    logic [msh_pkg::PEER_W-1:0]   w_wr_addr;
    logic                         w_we_sent;
    logic                         w_we_recv;
    logic [63:0]                  w_wd_sent;
    logic [63:0]                  w_wd_recv;
    logic [msh_pkg::BIN_W-1:0]    w_bin_addr;
    logic [63:0]                  w_bin_rd;
    logic                         w_bin_in_range;
    logic                         w_peer_in_range;
    logic                         w_idx_peer_ok;
    logic                         w_has_peer;
    logic                         w_rec_ok;
    logic                         w_is_rec;
    logic [msh_pkg::EXT_W-1:0]    w_ext_cand;

    assign o_stat.clear_last = (32'(r_clr_addr) == 32'(msh_pkg::PEERS - 1));

    // beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_in_cmd;
            r_bytes <= i_bytes;
            r_dir   <= i_direction;
            r_peer  <= i_peer;
            r_idx   <= i_read_index;
            r_bin   <= msh_pkg::bin_of(i_bytes);
        end
    end

    assign w_is_rec        = (r_cmd == msh_pkg::CMD_RECORD);
    assign w_has_peer      = ((r_dir == msh_pkg::DIR_SEND) || (r_dir == msh_pkg::DIR_RECV))
                             && !r_peer[10];
    assign w_peer_in_range = (32'($unsigned(r_peer)) < 32'(msh_pkg::PEERS));
    assign w_rec_ok        = w_has_peer && w_peer_in_range;
    assign w_idx_peer_ok   = (32'(r_idx) < 32'(msh_pkg::PEERS));
    assign w_bin_in_range  = (32'(r_idx) < 32'(msh_pkg::NUM_BINS));

    // peer memories: one read in the capture cycle, one write at commit or clear
    assign w_rd_addr = (i_in_cmd == msh_pkg::CMD_RECORD) ? i_peer[msh_pkg::PEER_W-1:0]
                                                         : i_read_index[msh_pkg::PEER_W-1:0];
    assign w_wr_addr = i_cmd.clear_step ? r_clr_addr : r_peer[msh_pkg::PEER_W-1:0];
    assign w_we_sent = i_cmd.clear_step
                       || (i_cmd.commit && w_is_rec && w_rec_ok && r_dir == msh_pkg::DIR_SEND);
    assign w_we_recv = i_cmd.clear_step
                       || (i_cmd.commit && w_is_rec && w_rec_ok && r_dir == msh_pkg::DIR_RECV);
    assign w_wd_sent = i_cmd.clear_step ? 64'd0 : (r_sent_rd + 64'(r_bytes));
    assign w_wd_recv = i_cmd.clear_step ? 64'd0 : (r_recv_rd + 64'(r_bytes));

    always_ff @(posedge i_clk) begin
        if (w_we_sent) begin
            sent_mem[w_wr_addr] <= w_wd_sent;
        end
        if (i_cmd.capture) begin
            r_sent_rd <= sent_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_recv) begin
            recv_mem[w_wr_addr] <= w_wd_recv;
        end
        if (i_cmd.capture) begin
            r_recv_rd <= recv_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + msh_pkg::PEER_W'(1);
        end
    end

    // bin counters share one read mux between increment and readout
    assign w_bin_addr = w_is_rec ? r_bin : r_idx[msh_pkg::BIN_W-1:0];
    assign w_bin_rd   = (w_is_rec || w_bin_in_range) ? r_bins[w_bin_addr] : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < msh_pkg::NUM_BINS; i++) begin
                r_bins[i] <= 64'd0;
            end
        end else if (i_cmd.commit && w_is_rec) begin
            r_bins[r_bin] <= w_bin_rd + 64'd1;
        end
    end

    // extent
    assign w_ext_cand = msh_pkg::EXT_W'(r_peer[msh_pkg::PEER_W-1:0]) + msh_pkg::EXT_W'(1);

    always_comb begin
        n_ext = r_ext;
        if (w_is_rec && w_rec_ok && (w_ext_cand > r_ext)) begin
            n_ext = w_ext_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext <= '0;
        end else if (i_cmd.commit) begin
            r_ext <= n_ext;
        end
    end

    // result
    always_comb begin
        n_status = msh_pkg::ST_OK;
        n_bc     = 64'd0;
        n_sb     = 64'd0;
        n_rb     = 64'd0;
        case (r_cmd)
            msh_pkg::CMD_RECORD: begin
                if (w_has_peer && !w_peer_in_range) begin
                    n_status = msh_pkg::ST_PEER_RANGE;
                end
            end
            msh_pkg::CMD_READ_BIN: begin
                if (w_bin_in_range) begin
                    n_bc = w_bin_rd;
                end else begin
                    n_status = msh_pkg::ST_IDX_RANGE;
                end
            end
            msh_pkg::CMD_READ_PEER: begin
                if (w_idx_peer_ok) begin
                    n_sb = r_sent_rd;
                    n_rb = r_recv_rd;
                end else begin
                    n_status = msh_pkg::ST_IDX_RANGE;
                end
            end
            default: n_status = msh_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status      <= n_status;
            r_bc          <= n_bc;
            r_sb          <= n_sb;
            r_rb          <= n_rb;
            o_peer_extent <= n_ext;
        end
    end

    assign o_status     = r_status;
    assign o_bin_count  = r_bc;
    assign o_sent_bytes = r_sb;
    assign o_recv_bytes = r_rb;

endmodule

// ----- hdl/message_size_histogram_peer_counters.sv -----
// top level of the message size histogram with per-peer byte counters
//
// usage:
//   i_in  : sink channel of message events and read commands (valid/ready)
//           cmd record adds one to the size bin and, for a send or receive
//           with a peer in range, adds bytes to that peer's sent/recv total
//           cmd read bin / read peer return a bin count or the peer totals
//   o_res : source channel, exactly one result beat per accepted beat,
//           always carrying the current peer extent
// result : an accepted beat is captured into registers; its result is registered
//           at commit, which waits while o_res holds an untaken beat
// intake : one beat in work at a time; the next beat is taken only after
//           the previous one has committed
// reset : bin counters and extent clear at once; both 1024-entry peer
//           memories are then cleared one entry a cycle, with i_in.ready
//           low throughout the sweep
// stall : while o_res holds an untaken beat, the next beat may still be
//           accepted; it then waits at commit until the result register frees
module message_size_histogram_peer_counters (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msh_in_if.sink        i_in,
    msh_out_if.source     o_res
);

    msh_pkg::t_dp_cmd  w_cmd;
    msh_pkg::t_dp_stat w_stat;
    logic              w_in_ready;
    logic              w_out_valid;

    // control: clear sweep, intake, commit
    msh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // counters, memories and the result register
    msh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_cmd      (i_in.cmd),
        .i_bytes       (i_in.bytes),
        .i_direction   (i_in.direction),
        .i_peer        (i_in.peer),
        .i_read_index  (i_in.read_index),
        .o_status      (o_res.status),
        .o_bin_count   (o_res.bin_count),
        .o_sent_bytes  (o_res.sent_bytes),
        .o_recv_bytes  (o_res.recv_bytes),
        .o_peer_extent (o_res.peer_extent)
    );

    assign i_in.ready  = w_in_ready;
    assign o_res.valid = w_out_valid;

`ifndef SYNTHESIS
    // one beat in flight: no intake in the cycle after an accept
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("beat accepted while previous beat still in work");

    // commit only into a free or draining result register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_res.valid || o_res.ready))
        else $error("result overwritten before it was taken");

    // clear sweep never overlaps intake or commit
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_step |-> (!w_cmd.capture && !w_cmd.commit && !i_in.ready))
        else $error("memory clear overlaps beat processing");

    // a result never carries the unused status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.status != msh_pkg::ST_UNUSED))
        else $error("unused status code on result");
`endif

endmodule
